@@ hw/rtl/urx_pkg.sv @@
`timescale 1ns / 1ps

package urx_pkg;

  // ring geometry
  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;

  // field widths
  localparam int MODE_W    = 2;
  localparam int DATA_W    = 8;
  localparam int COUNT_W   = 6;
  localparam int TICKS_W   = 16;
  localparam int CFG_IDX_W = 2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_EN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS = 2'd3;

  localparam logic [TICKS_W-1:0] BIT_TICKS_RESET = 16'd104;

  // input request payload
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              line_level;
  } urx_in_t;

  // result payload
  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               data_valid;
    logic [COUNT_W-1:0] bytes_waiting;
    logic               overflow;
    logic               byte_stored;
  } urx_out_t;

endpackage

@@ hw/rtl/uart_receiver_with_fifo.sv @@
`timescale 1ns / 1ps

// 8-bit serial receiver (LSB first, start/optional parity/stop slots) with a
// receive ring of urx_pkg::RING_DEPTH bytes, of which one slot stays empty.
// Every request is a line sample tick, a read that pops the oldest byte, or
// a peek. The block takes one request per clock unless the output stalls
// and returns its result in the cycle after acceptance; the ring read port
// is registered. A new request is taken in the same cycle that the pending
// result is taken. The ring memory has no reset and needs no clearing pass:
// only entries between head and tail are ever read. Setting enable after it
// was clear empties the ring and clears the sticky overflow flag.
module uart_receiver_with_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  urx_pkg::urx_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output urx_pkg::urx_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [urx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [urx_pkg::TICKS_W-1:0]         cfg_wdata
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CENTER,
    PH_DATA,
    PH_PARITY,
    PH_STOP
  } phase_t;

  localparam int                       PW       = urx_pkg::PTR_W;
  localparam logic [PW-1:0]            PTR_LAST = PW'(urx_pkg::RING_DEPTH - 1);
  localparam logic [PW:0]              DEPTH_X  = (PW+1)'(urx_pkg::RING_DEPTH);

  // configuration registers
  logic                        enable_r;
  logic                        invert_r;
  logic                        parity_en_r;
  logic [urx_pkg::TICKS_W-1:0] bit_ticks_r;

  // receiver and ring state
  phase_t                      phase_r, phase_nxt;
  logic [urx_pkg::TICKS_W-1:0] countdown_r, countdown_nxt;
  logic [3:0]                  bits_left_r, bits_left_nxt;
  logic [urx_pkg::DATA_W-1:0]  shift_r, shift_nxt;
  logic [PW-1:0]               head_r, head_nxt;
  logic [PW-1:0]               tail_r, tail_nxt;
  logic                        overflow_r, overflow_nxt;

  // ring memory and its registered read port
  logic [urx_pkg::DATA_W-1:0]  ring_mem [urx_pkg::RING_DEPTH];
  logic [urx_pkg::DATA_W-1:0]  ram_q_r;

  // result register
  logic                        out_valid_r;
  urx_pkg::urx_out_t           res_r, res_nxt;

  logic                        accept;
  logic                        push;
  logic [urx_pkg::DATA_W-1:0]  push_byte;
  logic                        do_tick;
  logic                        do_fetch;
  logic                        ring_empty;
  logic [PW-1:0]               tail_inc;
  logic [PW-1:0]               head_inc;
  logic [urx_pkg::TICKS_W-1:0] half_ticks;
  logic [urx_pkg::TICKS_W-1:0] full_ticks;
  logic [PW:0]                 count_x;
  logic [31:0]                 count_ext;

  // handshake: advance whenever the result register is free or being taken
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign ring_empty = (head_r == tail_r);
  assign tail_inc   = (tail_r == PTR_LAST) ? '0 : tail_r + PW'(1);
  assign head_inc   = (head_r == PTR_LAST) ? '0 : head_r + PW'(1);
  assign half_ticks = (bit_ticks_r[urx_pkg::TICKS_W-1:1] == '0) ?
                      urx_pkg::TICKS_W'(1) : {1'b0, bit_ticks_r[urx_pkg::TICKS_W-1:1]};
  assign full_ticks = (bit_ticks_r == '0) ? urx_pkg::TICKS_W'(1) : bit_ticks_r;

  assign do_tick  = enable_r && (in_data.mode == urx_pkg::MODE_TICK);
  assign do_fetch = enable_r && !ring_empty &&
                    ((in_data.mode == urx_pkg::MODE_READ) ||
                     (in_data.mode == urx_pkg::MODE_PEEK));

  // receiver sequencing and ring pointers for one request
  always_comb begin
    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    bits_left_nxt = bits_left_r;
    shift_nxt     = shift_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    overflow_nxt  = overflow_r;
    push          = 1'b0;
    push_byte     = shift_r;

    if (do_tick) begin
      if (phase_r == PH_IDLE) begin
        if (in_data.line_level == invert_r) begin
          phase_nxt     = PH_CENTER;
          countdown_nxt = half_ticks;
        end
      end else if (countdown_r > urx_pkg::TICKS_W'(1)) begin
        countdown_nxt = countdown_r - urx_pkg::TICKS_W'(1);
      end else begin
        countdown_nxt = full_ticks;
        case (phase_r)
          PH_CENTER: begin
            phase_nxt     = PH_DATA;
            bits_left_nxt = 4'd8;
            shift_nxt     = '0;
          end
          PH_DATA: begin
            shift_nxt     = {in_data.line_level, shift_r[urx_pkg::DATA_W-1:1]};
            bits_left_nxt = bits_left_r - 4'd1;
            if (bits_left_r == 4'd1) begin
              push_byte = invert_r ? ~shift_nxt : shift_nxt;
              if (tail_inc != head_r) begin
                push     = 1'b1;
                tail_nxt = tail_inc;
              end else begin
                overflow_nxt = 1'b1;
              end
              phase_nxt = parity_en_r ? PH_PARITY : PH_STOP;
            end
          end
          PH_PARITY: begin
            phase_nxt = PH_STOP;
          end
          default: begin
            phase_nxt     = PH_IDLE;
            countdown_nxt = '0;
            bits_left_nxt = '0;
            shift_nxt     = '0;
          end
        endcase
      end
    end

    if (do_fetch && (in_data.mode == urx_pkg::MODE_READ)) begin
      head_nxt = head_inc;
    end
  end

  // fill level after the request
  always_comb begin
    if (tail_nxt >= head_nxt) begin
      count_x = {1'b0, tail_nxt} - {1'b0, head_nxt};
    end else begin
      count_x = {1'b0, tail_nxt} + DEPTH_X - {1'b0, head_nxt};
    end
    count_ext = 32'(count_x);
  end

  // result fields, data is filled from the memory read port
  always_comb begin
    res_nxt               = '0;
    res_nxt.data_valid    = do_fetch;
    res_nxt.bytes_waiting = enable_r ? count_ext[urx_pkg::COUNT_W-1:0] : '0;
    res_nxt.overflow      = overflow_nxt;
    res_nxt.byte_stored   = push;
  end

  // state, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      invert_r    <= 1'b0;
      parity_en_r <= 1'b0;
      bit_ticks_r <= urx_pkg::BIT_TICKS_RESET;
      phase_r     <= PH_IDLE;
      countdown_r <= '0;
      bits_left_r <= '0;
      shift_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          urx_pkg::CFG_ENABLE: begin
            if (cfg_wdata[0] && !enable_r) begin
              head_r     <= '0;
              tail_r     <= '0;
              overflow_r <= 1'b0;
            end
            if (cfg_wdata[0] != enable_r) begin
              phase_r     <= PH_IDLE;
              countdown_r <= '0;
              bits_left_r <= '0;
              shift_r     <= '0;
            end
            enable_r <= cfg_wdata[0];
          end
          urx_pkg::CFG_INVERT:    invert_r    <= cfg_wdata[0];
          urx_pkg::CFG_PARITY_EN: parity_en_r <= cfg_wdata[0];
          urx_pkg::CFG_BIT_TICKS: bit_ticks_r <= cfg_wdata;
          default: ;
        endcase
      end else if (accept) begin
        phase_r     <= phase_nxt;
        countdown_r <= countdown_nxt;
        bits_left_r <= bits_left_nxt;
        shift_r     <= shift_nxt;
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        overflow_r  <= overflow_nxt;
      end

      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, held while the output is stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  // ring write port
  always_ff @(posedge clk) begin
    if (accept && push) begin
      ring_mem[tail_r] <= push_byte;
    end
  end

  // ring read port, registered
  always_ff @(posedge clk) begin
    if (accept) begin
      ram_q_r <= ring_mem[head_r];
    end
  end

  // output payload
  always_comb begin
    out_data      = res_r;
    out_data.data = res_r.data_valid ? ram_q_r : '0;
  end

endmodule
